[hdl/hdlc_style_deframer_crc_check_unit_assert.svh]
// Assertion macros used by the HDLC deframer top level.
`ifndef HDLC_STYLE_DEFRAMER_CRC_CHECK_UNIT_ASSERT_SVH
`define HDLC_STYLE_DEFRAMER_CRC_CHECK_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HDLC_DFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hdlc deframer: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define HDLC_DFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hdlc deframer: next-cycle check failed");

`endif

[hdl/hdlc_dfr_pkg.sv]
// Types and constants shared by the HDLC deframer modules.
`default_nettype none

package hdlc_dfr_pkg;

   localparam int unsigned CountW   = 7;
   localparam int unsigned LenW     = 6;
   localparam int unsigned MaxFrame = 64;
   localparam int unsigned QDepth   = 4;
   localparam int unsigned QPtrW    = 2;

   localparam logic [7:0]  FLAG_BYTE = 8'h7E;
   localparam logic [7:0]  ESC_BYTE  = 8'h7D;
   localparam logic [7:0]  ESC_FLAG  = 8'h5E;
   localparam logic [7:0]  ESC_ESC   = 8'h5D;
   localparam logic [15:0] CRC_POLY  = 16'h8408;
   localparam logic [15:0] CRC_INIT  = 16'hFFFF;

   typedef logic [CountW-1:0] count_type;
   typedef logic [LenW-1:0]   len_type;

   typedef enum logic [1:0] {
      MODE_HUNT = 2'd0,
      MODE_DATA = 2'd1,
      MODE_ESC  = 2'd2
   } rx_mode_type;

   typedef enum logic [1:0] {
      CMD_STORE = 2'd0,
      CMD_CLOSE = 2'd1,
      CMD_DROP  = 2'd2
   } cmd_kind_type;

   typedef enum logic {
      BACK_CMD  = 1'b0,
      BACK_EMIT = 1'b1
   } back_state_type;

   // One command from the front end: a decoded byte to store at an index,
   // a frame close with the decoded byte count, or a frame drop.
   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      count_type    count;
   } cmd_type;

endpackage

`default_nettype wire

[hdl/hdlc_dfr_front.sv]
// Front end: delimiter hunt, unstuffing, length limit and command issue.
`default_nettype none

module hdlc_dfr_front
   import hdlc_dfr_pkg::*;
#(
   parameter int unsigned BUFFER_DEPTH = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       csr_wen,
   input  wire logic [6:0] csr_wdata,
   input  wire logic       q_full,
   output logic            cmd_push,
   output cmd_type         cmd_out
);

   localparam int unsigned BufCap = (BUFFER_DEPTH < MaxFrame) ? BUFFER_DEPTH : MaxFrame;
   localparam count_type CapCount = count_type'(BufCap);
   localparam count_type ResetMax = count_type'(MaxFrame);

   rx_mode_type mode_ff, mode_in;
   count_type   count_ff, count_in;
   count_type   max_ff;
   count_type   limit;
   logic        accept;
   logic        store_ok;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign limit     = (max_ff > CapCount) ? CapCount : max_ff;
   assign store_ok  = count_ff < limit;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_HUNT;
         count_ff <= '0;
         max_ff   <= ResetMax;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         if (csr_wen) begin
            max_ff <= csr_wdata;
         end
      end
   end

   always_comb begin
      mode_in       = mode_ff;
      count_in      = count_ff;
      cmd_push      = 1'b0;
      cmd_out.kind  = CMD_DROP;
      cmd_out.data  = req_rx_byte;
      cmd_out.count = count_ff;
      if (accept) begin
         case (mode_ff)
            MODE_DATA: begin
               if (req_rx_byte == ESC_BYTE) begin
                  mode_in = MODE_ESC;
               end else if (req_rx_byte == FLAG_BYTE) begin
                  cmd_push     = 1'b1;
                  cmd_out.kind = CMD_CLOSE;
                  count_in     = '0;
                  mode_in      = MODE_HUNT;
               end else if (store_ok) begin
                  cmd_push     = 1'b1;
                  cmd_out.kind = CMD_STORE;
                  count_in     = count_ff + count_type'(1);
               end else begin
                  cmd_push = 1'b1;
                  count_in = '0;
                  mode_in  = MODE_HUNT;
               end
            end
            MODE_ESC: begin
               if ((req_rx_byte inside {ESC_FLAG, ESC_ESC}) && store_ok) begin
                  cmd_push     = 1'b1;
                  cmd_out.kind = CMD_STORE;
                  cmd_out.data = (req_rx_byte == ESC_FLAG) ? FLAG_BYTE : ESC_BYTE;
                  count_in     = count_ff + count_type'(1);
                  mode_in      = MODE_DATA;
               end else begin
                  // Bad escape or overflow: the frame is abandoned.
                  cmd_push = 1'b1;
                  count_in = '0;
                  mode_in  = MODE_HUNT;
               end
            end
            default: begin
               if (req_rx_byte == FLAG_BYTE) begin
                  count_in = '0;
                  mode_in  = MODE_DATA;
               end else begin
                  mode_in = MODE_HUNT;
               end
            end
         endcase
      end
   end

endmodule

`default_nettype wire

[hdl/hdlc_dfr_cmdq.sv]
// Small command FIFO between the front end and the back end.
`default_nettype none

module hdlc_dfr_cmdq
   import hdlc_dfr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output cmd_type      head_cmd,
   output logic         full,
   output logic         empty
);

   cmd_type                entry_ff [QDepth];
   logic [QPtrW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [QPtrW:0]         fill_ff;

   assign full     = fill_ff == (QPtrW+1)'(QDepth);
   assign empty    = fill_ff == '0;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPtrW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPtrW'(1);
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + (QPtrW+1)'(1);
         end else if (pop && !push) begin
            fill_ff <= fill_ff - (QPtrW+1)'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

[hdl/hdlc_dfr_back.sv]
// Back end: frame buffer, running CRC, frame check and payload readout.
`default_nettype none

module hdlc_dfr_back
   import hdlc_dfr_pkg::*;
#(
   parameter int unsigned BUFFER_DEPTH = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    cmd_valid,
   input  wire cmd_type cmd_in,
   output logic         cmd_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output logic [7:0]   rsp_payload_byte,
   output logic         rsp_is_last,
   output len_type      rsp_payload_length
);

   localparam int unsigned BufWords = (BUFFER_DEPTH < MaxFrame) ? BUFFER_DEPTH : MaxFrame;
   localparam int unsigned AddrW    = $clog2(BufWords);

   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

   logic [7:0]     frame_mem_ff [BufWords];
   back_state_type state_ff, state_in;
   logic [15:0]    crc_ff, crc_in;
   logic [7:0]     hold_new_ff, hold_new_in;
   logic [7:0]     hold_old_ff, hold_old_in;
   len_type        rd_idx_ff, rd_idx_in;
   len_type        plen_ff, plen_in;
   logic           pend_ff;
   logic           pend_last_ff;
   len_type        pend_len_ff;
   logic [7:0]     rd_data_ff;
   logic           rsp_valid_ff;
   logic [7:0]     rsp_byte_ff;
   logic           rsp_last_ff;
   len_type        rsp_len_ff;
   logic           mem_we;
   logic           issue;
   logic           issue_last;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_byte   = rsp_byte_ff;
   assign rsp_is_last        = rsp_last_ff;
   assign rsp_payload_length = rsp_len_ff;
   assign issue_last         = rd_idx_ff == (plen_ff - len_type'(1));

   always_comb begin
      state_in    = state_ff;
      crc_in      = crc_ff;
      hold_new_in = hold_new_ff;
      hold_old_in = hold_old_ff;
      rd_idx_in   = rd_idx_ff;
      plen_in     = plen_ff;
      cmd_pop     = 1'b0;
      mem_we      = 1'b0;
      issue       = 1'b0;
      case (state_ff)
         BACK_CMD: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd_in.kind)
                  CMD_STORE: begin
                     mem_we      = 1'b1;
                     hold_new_in = cmd_in.data;
                     hold_old_in = hold_new_ff;
                     // The CRC trails the stored bytes by two.
                     if (cmd_in.count >= count_type'(2)) begin
                        crc_in = crc_fold(crc_ff, hold_old_ff);
                     end
                  end
                  CMD_CLOSE: begin
                     crc_in = CRC_INIT;
                     if ((cmd_in.count > count_type'(2)) &&
                         ({hold_new_ff, hold_old_ff} == ~crc_ff)) begin
                        state_in  = BACK_EMIT;
                        rd_idx_in = '0;
                        plen_in   = len_type'(cmd_in.count - count_type'(2));
                     end
                  end
                  default: begin
                     crc_in = CRC_INIT;
                  end
               endcase
            end
         end
         BACK_EMIT: begin
            if (!pend_ff && (!rsp_valid_ff || !rsp_stall)) begin
               issue     = 1'b1;
               rd_idx_in = rd_idx_ff + len_type'(1);
               if (issue_last) begin
                  state_in = BACK_CMD;
               end
            end
         end
         default: begin
            state_in = BACK_CMD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_CMD;
         crc_ff       <= CRC_INIT;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         crc_ff       <= crc_in;
         pend_ff      <= issue;
         rsp_valid_ff <= pend_ff || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      hold_new_ff <= hold_new_in;
      hold_old_ff <= hold_old_in;
      rd_idx_ff   <= rd_idx_in;
      plen_ff     <= plen_in;
      if (issue) begin
         rd_data_ff   <= frame_mem_ff[rd_idx_ff[AddrW-1:0]];
         pend_last_ff <= issue_last;
         pend_len_ff  <= plen_ff;
      end
      if (mem_we) begin
         frame_mem_ff[cmd_in.count[AddrW-1:0]] <= cmd_in.data;
      end
      if (pend_ff) begin
         rsp_byte_ff <= rd_data_ff;
         rsp_last_ff <= pend_last_ff;
         rsp_len_ff  <= pend_len_ff;
      end
   end

endmodule

`default_nettype wire

[hdl/hdlc_style_deframer_crc_check_unit.sv]
// Top level of the HDLC-style deframer with CRC-16/X-25 frame check.
`default_nettype none

// Receives one raw line byte per transaction on the req_ channel, finds frames
// between 0x7E delimiters, removes 0x7D escapes and checks the CRC-16/X-25
// carried in the last two decoded bytes (low byte first). Each good frame's
// payload comes out on the rsp_ channel as one transaction per byte, with
// rsp_is_last on the final byte and rsp_payload_length on every byte. Frames
// that are too short, fail the CRC, contain a bad escape or exceed the
// csr_ frame limit (capped at the buffer size) produce nothing. The front end
// takes one line byte per cycle while its 4-entry command queue has room; the
// back end stores one decoded byte per cycle outside readout and checks a
// closing frame as it pops the close command. Readout sends each byte through
// a registered buffer read and the output register, with no new read while one
// is pending, and the next frame's bytes wait in the queue, so req_stall rises
// once the queue fills. Write the limit register only while the block is idle.
module hdlc_style_deframer_crc_check_unit
   import hdlc_dfr_pkg::*;
#(
   parameter int unsigned BUFFER_DEPTH = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_payload_byte,
   output logic            rsp_is_last,
   output logic [5:0]      rsp_payload_length,
   input  wire logic       csr_wen,
   input  wire logic [6:0] csr_wdata
);

   `include "hdlc_style_deframer_crc_check_unit_assert.svh"

   // Commands flow front end -> queue -> back end, strictly in order, so the
   // buffer is never overwritten while a frame is still being read out.
   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    cmd_push;
   logic    cmd_pop;
   logic    q_full;
   logic    q_empty;

   hdlc_dfr_front #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .cmd_push    (cmd_push),
      .cmd_out     (push_cmd)
   );

   hdlc_dfr_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (push_cmd),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   hdlc_dfr_back #(
      .BUFFER_DEPTH (BUFFER_DEPTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_valid          (!q_empty),
      .cmd_in             (head_cmd),
      .cmd_pop            (cmd_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_is_last        (rsp_is_last),
      .rsp_payload_length (rsp_payload_length)
   );

   // The front end must never push into a full queue.
   `HDLC_DFR_ASSERT_IMPL(a_no_push_full, clock, reset, cmd_push, !q_full)
   // The back end must never pop an empty queue.
   `HDLC_DFR_ASSERT_IMPL(a_no_pop_empty, clock, reset, cmd_pop, !q_empty)
   // A push into an empty queue, with nothing popped, leaves a command waiting.
   `HDLC_DFR_ASSERT_NEXT(a_push_lands, clock, reset, cmd_push && q_empty, !q_empty)
   // Every delivered payload byte belongs to a frame of at least one byte.
   `HDLC_DFR_ASSERT_IMPL(a_len_nonzero, clock, reset, rsp_valid, rsp_payload_length != 6'd0)

endmodule

`default_nettype wire

[verif/hdlc_dfr_scoreboard_pkg.sv]
// Scoreboard class that predicts and checks the payload transactions of the HDLC deframer.
package hdlc_dfr_scoreboard_pkg;
   import hdlc_dfr_pkg::*;

   typedef struct {
      logic [7:0] data;
      logic       last;
      len_type    len;
   } payload_beat_t;

   class payload_scoreboard;
      rx_mode_type   mode;
      count_type     held;
      logic [7:0]    frame_bytes[MaxFrame];
      logic [15:0]   fcs_acc;
      logic [6:0]    limit_reg;
      payload_beat_t payload_due[$];
      int unsigned   fail_count;

      function new();
         mode       = MODE_HUNT;
         held       = '0;
         fcs_acc    = CRC_INIT;
         limit_reg  = 7'd64;
         fail_count = 0;
      endfunction

      // One byte folded into a reflected CRC-16/X-25 register.
      static function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
         logic [15:0] r;
         r = c ^ {8'h00, b};
         for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
         return r;
      endfunction

      function void set_limit(input logic [6:0] v);
         limit_reg = v;
      endfunction

      function int unsigned eff_limit();
         return (limit_reg > MaxFrame) ? MaxFrame : limit_reg;
      endfunction

      function int pending();
         return payload_due.size();
      endfunction

      function void abandon_frame();
         held    = '0;
         fcs_acc = CRC_INIT;
         mode    = MODE_HUNT;
      endfunction

      // Returns 0 when the frame overflowed and was dropped.
      function bit keep_byte(input logic [7:0] b);
         if (held >= eff_limit()) begin
            abandon_frame();
            return 1'b0;
         end
         if (held >= 2)
            fcs_acc = crc_step(fcs_acc, frame_bytes[held - 2]);
         frame_bytes[held] = b;
         held = held + 1'b1;
         return 1'b1;
      endfunction

      function void close_frame();
         int unsigned   n;
         int unsigned   plen;
         payload_beat_t beat;
         n = held;
         if (n > 2 && n <= MaxFrame) begin
            if ({frame_bytes[n - 1], frame_bytes[n - 2]} == ~fcs_acc) begin
               plen = n - 2;
               for (int unsigned i = 0; i < plen; i++) begin
                  beat.data = frame_bytes[i];
                  beat.last = (i + 1 == plen);
                  beat.len  = len_type'(plen);
                  payload_due.push_back(beat);
               end
            end
         end
         abandon_frame();
      endfunction

      // Called once for every accepted line byte.
      function void note_line_byte(input logic [7:0] b);
         case (mode)
            MODE_DATA: begin
               if (b == ESC_BYTE)
                  mode = MODE_ESC;
               else if (b == FLAG_BYTE)
                  close_frame();
               else
                  void'(keep_byte(b));
            end
            MODE_ESC: begin
               if (b == ESC_FLAG || b == ESC_ESC) begin
                  if (keep_byte((b == ESC_FLAG) ? FLAG_BYTE : ESC_BYTE))
                     mode = MODE_DATA;
               end else begin
                  abandon_frame();
               end
            end
            default: begin
               if (b == FLAG_BYTE) begin
                  held    = '0;
                  fcs_acc = CRC_INIT;
                  mode    = MODE_DATA;
               end
            end
         endcase
      endfunction

      task report_mismatch(input string msg);
         $display("MISMATCH: %s", msg);
         fail_count++;
      endtask

      task check_result(input logic [7:0] data, input logic last, input len_type len);
         payload_beat_t want;
         if (payload_due.size() == 0) begin
            report_mismatch($sformatf("unexpected payload byte %h last %b len %0d",
                                      data, last, len));
            return;
         end
         want = payload_due.pop_front();
         if (data !== want.data)
            report_mismatch($sformatf("payload byte %h, expected %h", data, want.data));
         if (last !== want.last)
            report_mismatch($sformatf("is_last %b, expected %b", last, want.last));
         if (len !== want.len)
            report_mismatch($sformatf("payload length %0d, expected %0d", len, want.len));
      endtask

      task check_drained();
         if (payload_due.size() != 0)
            report_mismatch($sformatf("%0d payload bytes never arrived", payload_due.size()));
      endtask
   endclass
endpackage

[verif/tb.sv]
// Testbench top that drives line bytes into the HDLC deframer and checks its payload output.
module tb;
   import hdlc_dfr_pkg::*;
   import hdlc_dfr_scoreboard_pkg::*;

   // Kinds of line traffic that the random part generates.
   typedef enum int {
      FRAME_GOOD,
      FRAME_BAD_CRC,
      FRAME_BAD_ESC,
      FRAME_OVERLONG,
      FRAME_SHORT
   } frame_kind_e;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_payload_byte;
   logic       rsp_is_last;
   logic [5:0] rsp_payload_length;
   logic       csr_wen = 1'b0;
   logic [6:0] csr_wdata = 7'd0;

   payload_scoreboard sb;
   int  line_bytes_sent = 0;
   bit  line_gaps_on = 1'b1;
   // Set by the stimulus to ask the receiver for one long hold-off.
   bit  hold_go = 1'b0;

   hdlc_style_deframer_crc_check_unit #(
      .BUFFER_DEPTH(64)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_is_last        (rsp_is_last),
      .rsp_payload_length (rsp_payload_length),
      .csr_wen            (csr_wen),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // Offers one line byte, with an optional random gap in front of it, and
   // returns at the edge where the transaction is accepted. The valid is left
   // high so that a following byte can go out back to back. It must be called
   // at a rising edge.
   task automatic push_line_byte(input logic [7:0] b);
      int r;
      int n;
      n = 0;
      if (line_gaps_on) begin
         r = $urandom_range(0, 99);
         if (r >= 92)
            n = $urandom_range(8, 40);
         else if (r >= 60)
            n = $urandom_range(1, 3);
      end
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_line_byte(b);
      line_bytes_sent++;
   endtask

   // Sends one frame: the opening delimiter, the stuffed payload and CRC, and
   // the closing delimiter. A bad-escape frame stops right after the broken
   // escape pair and an overlong frame has no closing delimiter, so that the
   // line is back to hunting for the next frame either way.
   task automatic send_frame(input frame_kind_e kind, input logic [7:0] pay[$]);
      logic [7:0]  body[$];
      logic [15:0] fcs;
      logic [7:0]  bad;
      int          cut;
      body = pay;
      if (kind != FRAME_SHORT) begin
         fcs = CRC_INIT;
         foreach (pay[i]) fcs = payload_scoreboard::crc_step(fcs, pay[i]);
         fcs = ~fcs;
         if (kind == FRAME_BAD_CRC)
            fcs = fcs ^ (16'h0001 << $urandom_range(0, 15));
         body.push_back(fcs[7:0]);
         body.push_back(fcs[15:8]);
      end
      cut = (body.size() > 0) ? $urandom_range(0, body.size() - 1) : 0;
      push_line_byte(FLAG_BYTE);
      foreach (body[i]) begin
         if (kind == FRAME_BAD_ESC && i == cut) begin
            do bad = 8'($urandom); while (bad == ESC_FLAG || bad == ESC_ESC);
            push_line_byte(ESC_BYTE);
            push_line_byte(bad);
            return;
         end
         if (body[i] == FLAG_BYTE || body[i] == ESC_BYTE) begin
            push_line_byte(ESC_BYTE);
            push_line_byte((body[i] == FLAG_BYTE) ? ESC_FLAG : ESC_ESC);
         end else begin
            push_line_byte(body[i]);
         end
      end
      if (kind != FRAME_OVERLONG)
         push_line_byte(FLAG_BYTE);
   endtask

   // Random traffic until about n more line bytes have gone out. Most of it is
   // well-formed frames with random content, sized against the limit now in
   // force, with corrupted, broken, overlong and short frames and loose noise
   // mixed in.
   task automatic run_random(input int n);
      int          stop;
      int          r;
      int          eff;
      int          maxpl;
      int          len;
      frame_kind_e kind;
      logic [7:0]  pay[$];
      logic [7:0]  b;
      stop = line_bytes_sent + n;
      while (line_bytes_sent < stop) begin
         line_gaps_on = !hold_go && ($urandom_range(0, 3) != 0);
         eff   = sb.eff_limit();
         maxpl = (eff >= 3) ? eff - 2 : 1;
         r     = $urandom_range(0, 99);
         if (r < 6) begin
            // Loose noise between frames; a raw delimiter is let through rarely.
            repeat ($urandom_range(1, 6)) begin
               b = 8'($urandom);
               if (b == FLAG_BYTE && $urandom_range(0, 9) != 0)
                  b = 8'h00;
               push_line_byte(b);
            end
            continue;
         end
         if (r < 70)
            kind = FRAME_GOOD;
         else if (r < 80)
            kind = FRAME_BAD_CRC;
         else if (r < 87)
            kind = FRAME_BAD_ESC;
         else if (r < 94)
            kind = FRAME_OVERLONG;
         else
            kind = FRAME_SHORT;
         r = $urandom_range(0, 99);
         case (kind)
            FRAME_OVERLONG: len = ((eff >= 3) ? maxpl + 1 : 1) + $urandom_range(0, 2);
            FRAME_SHORT:    len = $urandom_range(0, 2);
            default: begin
               if (r < 5)
                  len = maxpl;
               else if (r < 25)
                  len = $urandom_range(1, maxpl);
               else
                  len = $urandom_range(1, (maxpl < 8) ? maxpl : 8);
            end
         endcase
         pay.delete();
         repeat (len) begin
            r = $urandom_range(0, 9);
            if (r == 0)
               b = FLAG_BYTE;
            else if (r == 1)
               b = ESC_BYTE;
            else
               b = 8'($urandom);
            pay.push_back(b);
         end
         send_frame(kind, pay);
      end
   endtask

   // Stops offering, waits for every predicted payload byte, and then gives
   // the back end time to finish a frame that produces nothing, such as one
   // that failed its CRC.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_limit(input logic [6:0] v);
      csr_wen   <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_wen   <= 1'b0;
      sb.set_limit(v);
   endtask

   // Receiver: random stall pattern with mostly short stalls, a few long ones
   // and stretches with no stall at all. On request it holds off for a long
   // stretch, counted here, so the command queue fills and req_stall rises.
   initial begin
      int r;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_go) begin
            rsp_stall <= 1'b1;
            repeat (600) @(posedge clock);
            hold_go = 1'b0;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               rsp_stall <= 1'b0;
               repeat ($urandom_range(1, 20)) @(posedge clock);
            end else if (r < 90) begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(1, 3)) @(posedge clock);
            end else begin
               rsp_stall <= 1'b1;
               repeat ($urandom_range(20, 60)) @(posedge clock);
            end
         end
      end
   end

   // Every accepted payload transaction is compared with the oldest prediction.
   // The values read here are the ones from before this edge's updates.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall)
         sb.check_result(rsp_payload_byte, rsp_is_last, rsp_payload_length);
   end

   // Main stimulus.
   initial begin
      logic [7:0] pay[$];
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset limit of 64. Noise while hunting first.
      push_line_byte(8'h00);
      push_line_byte(8'hFF);
      // A good frame whose payload is both special bytes, so both escapes
      // appear on the line.
      pay.delete();
      pay.push_back(FLAG_BYTE);
      pay.push_back(ESC_BYTE);
      send_frame(FRAME_GOOD, pay);
      // The smallest good frame: one payload byte.
      pay.delete();
      pay.push_back(8'hFF);
      send_frame(FRAME_GOOD, pay);
      // An empty frame: two delimiters back to back.
      push_line_byte(FLAG_BYTE);
      push_line_byte(FLAG_BYTE);
      // A delimiter right after an escape drops the frame and does not open one.
      push_line_byte(FLAG_BYTE);
      push_line_byte(8'h41);
      push_line_byte(ESC_BYTE);
      push_line_byte(FLAG_BYTE);
      // A frame whose CRC bytes do not match.
      push_line_byte(FLAG_BYTE);
      push_line_byte(8'h01);
      push_line_byte(8'h00);
      push_line_byte(8'h00);
      push_line_byte(FLAG_BYTE);

      run_random(100);

      // Limit register above the buffer size is capped at the buffer.
      quiesce();
      write_limit(7'd127);
      run_random(80);

      // Smallest limit that still passes a frame: one payload byte.
      quiesce();
      write_limit(7'd3);
      run_random(60);

      // A limit of zero lets no frame through.
      quiesce();
      write_limit(7'd0);
      run_random(30);

      // A random limit, with one long hold-off by the receiver while the
      // sender keeps offering bytes without gaps.
      quiesce();
      write_limit(7'($urandom_range(4, 63)));
      hold_go = 1'b1;
      run_random(80);

      quiesce();
      write_limit(7'd64);
      run_random(60);

      quiesce();
      sb.check_drained();
      if (sb.fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule
